// ===== rtl/ipv6_header_chain_parser_assert.svh =====
// Assertion macros used by the parser's top-level RTL file.
`ifndef IPV6_HEADER_CHAIN_PARSER_ASSERT_SVH
`define IPV6_HEADER_CHAIN_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IHCP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IHCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ihcp_pkg.sv =====
package ihcp_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 65536;
    localparam int unsigned POS_W = 17;
    localparam int unsigned MAX_REC = 7;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Record kinds.
    localparam logic [3:0] K_DST_HI    = 4'd0;
    localparam logic [3:0] K_DST_LO    = 4'd1;
    localparam logic [3:0] K_SRC_HI    = 4'd2;
    localparam logic [3:0] K_SRC_LO    = 4'd3;
    localparam logic [3:0] K_HOP_LIMIT = 4'd4;
    localparam logic [3:0] K_SEGS_LEFT = 4'd5;
    localparam logic [3:0] K_ROUTE_HI  = 4'd6;
    localparam logic [3:0] K_ROUTE_LO  = 4'd7;
    localparam logic [3:0] K_FRAG_OFS  = 4'd8;
    localparam logic [3:0] K_FRAG_MORE = 4'd9;
    localparam logic [3:0] K_FRAG_ID   = 4'd10;
    localparam logic [3:0] K_PROTOCOL  = 4'd11;
    localparam logic [3:0] K_PAY_OFS   = 4'd12;
    localparam logic [3:0] K_TOO_SHORT = 4'd13;
    localparam logic [3:0] K_TRUNCATED = 4'd14;

    // Extension header types.
    localparam logic [7:0] HT_HOP_BY_HOP = 8'd0;
    localparam logic [7:0] HT_ROUTING    = 8'd43;
    localparam logic [7:0] HT_FRAGMENT   = 8'd44;
    localparam logic [7:0] HT_DEST_OPTS  = 8'd60;

    typedef struct packed {
        logic [3:0]  kind;
        logic [6:0]  index;
        logic [63:0] value;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [2:0] pend_cnt;
    } front_stat_t;

    typedef struct packed {
        logic [2:0] count;
    } queue_stat_t;

    function automatic logic is_ext(input logic [7:0] t);
        return (t == HT_HOP_BY_HOP) || (t == HT_ROUTING) ||
               (t == HT_FRAGMENT) || (t == HT_DEST_OPTS);
    endfunction

endpackage

// ===== rtl/ihcp_byte_if.sv =====
interface ihcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/ihcp_rec_if.sv =====
interface ihcp_rec_if;
    logic        valid;
    logic        ready;
    logic [3:0]  record_kind;
    logic [6:0]  record_index;
    logic [63:0] record_value;
    logic        last_of_run;

    modport source (output valid, output record_kind, output record_index,
                    output record_value, output last_of_run, input ready);
    modport sink (input valid, input record_kind, input record_index,
                  input record_value, input last_of_run, output ready);
endinterface

// ===== rtl/ihcp_front.sv =====
module ihcp_front
    import ihcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ihcp_byte_if.sink     byte_in,
    ihcp_rec_if.source    rec_q,
    output front_stat_t   stat
);

    localparam logic [1:0] PH_FIXED = 2'd0;
    localparam logic [1:0] PH_CHAIN = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       cur_reg, cur_next;
    logic [7:0]       nxt_reg, nxt_next;
    logic [POS_W-1:0] hstart_reg, hstart_next;
    logic [POS_W-1:0] hend_reg, hend_next;
    logic [7:0]       rtype_reg, rtype_next;
    logic [15:0]      frag_reg, frag_next;
    logic [7:0]       hop_reg, hop_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      halves_reg [4];
    logic [63:0]      halves_next [4];

    rec_t             pend_reg [MAX_REC];
    rec_t             pend_next [MAX_REC];
    logic [2:0]       cnt_reg, cnt_next;

    rec_t             recs [MAX_REC];
    logic [2:0]       n;
    logic             accept;
    logic             push;

    logic [7:0]       b;
    logic [POS_W-1:0] o;
    logic [POS_W-1:0] rel;
    logic [POS_W-1:0] tmp8;
    logic [7:0]       k;
    logic [17:0]      lim;
    logic [7:0]       nxt_eff;
    logic [POS_W-1:0] hend_eff;
    logic [15:0]      frag_new;
    logic             do_enter;
    logic [7:0]       ent_type;
    logic [POS_W-1:0] ent_start;

    assign b      = byte_in.data_byte;
    assign push   = (cnt_reg != 3'd0) && rec_q.ready;
    assign accept = byte_in.valid && byte_in.ready;

    // A new byte may enter once at most one record is left and it leaves now.
    assign byte_in.ready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && push);

    assign rec_q.valid        = (cnt_reg != 3'd0);
    assign rec_q.record_kind  = pend_reg[0].kind;
    assign rec_q.record_index = pend_reg[0].index;
    assign rec_q.record_value = pend_reg[0].value;
    assign rec_q.last_of_run  = pend_reg[0].last;
    assign stat.pend_cnt      = cnt_reg;

    // Parse one byte: update header state and build the list of records it causes.
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        nxt_next    = nxt_reg;
        hstart_next = hstart_reg;
        hend_next   = hend_reg;
        rtype_next  = rtype_reg;
        frag_next   = frag_reg;
        hop_next    = hop_reg;
        acc_next    = acc_reg;
        for (int i = 0; i < 4; i++)
        begin
            halves_next[i] = halves_reg[i];
        end
        for (int i = 0; i < MAX_REC; i++)
        begin
            recs[i] = '0;
        end
        n         = 3'd0;
        do_enter  = 1'b0;
        ent_type  = nxt_reg;
        ent_start = hend_reg;
        o         = pos_reg - hstart_reg;
        rel       = o - POS_W'(8);
        tmp8      = pos_reg - POS_W'(8);
        k         = 8'(rel[POS_W-1:4]) + 8'd1;
        lim       = {1'b0, hstart_reg} + 18'd8 + {6'd0, k, 4'd0};
        nxt_eff   = nxt_reg;
        hend_eff  = hend_reg;
        frag_new  = {frag_reg[7:0], b};

        if (phase_reg == PH_FIXED)
        begin
            if (pos_reg == POS_W'(6))
            begin
                nxt_next = b;
            end
            else if (pos_reg == POS_W'(7))
            begin
                hop_next = b;
            end
            if ((pos_reg >= POS_W'(8)) && (pos_reg <= POS_W'(39)))
            begin
                acc_next = {acc_reg[55:0], b};
                if (pos_reg[2:0] == 3'd7)
                begin
                    halves_next[tmp8[4:3]] = acc_next;
                end
            end
            if (pos_reg == POS_W'(39))
            begin
                recs[0] = '{kind: K_DST_HI, index: 7'd0, value: halves_reg[2], last: 1'b0};
                recs[1] = '{kind: K_DST_LO, index: 7'd0, value: acc_next, last: 1'b0};
                recs[2] = '{kind: K_SRC_HI, index: 7'd0, value: halves_reg[0], last: 1'b0};
                recs[3] = '{kind: K_SRC_LO, index: 7'd0, value: halves_reg[1], last: 1'b0};
                recs[4] = '{kind: K_HOP_LIMIT, index: 7'd0, value: {56'd0, hop_reg},
                            last: 1'b0};
                n         = 3'd5;
                do_enter  = 1'b1;
                ent_type  = nxt_reg;
                ent_start = POS_W'(40);
            end
            else if (byte_in.last_byte)
            begin
                recs[0] = '{kind: K_TOO_SHORT, index: 7'd0,
                            value: 64'(pos_reg) + 64'd1, last: 1'b0};
                n = 3'd1;
            end
        end
        else if (phase_reg == PH_CHAIN)
        begin
            if (pos_reg >= POS_W'(MAX_PACKET_BYTES))
            begin
                recs[0] = '{kind: K_TRUNCATED, index: 7'd0, value: 64'd0, last: 1'b0};
                n = 3'd1;
                phase_next = PH_DONE;
            end
            else
            begin
                // Common fields: next header and extension length.
                if (o == POS_W'(0))
                begin
                    nxt_eff = b;
                end
                else if ((o == POS_W'(1)) && (cur_reg != HT_FRAGMENT))
                begin
                    hend_eff = hstart_reg + {6'd0, b, 3'd0} + POS_W'(8);
                end
                nxt_next  = nxt_eff;
                hend_next = hend_eff;

                if (cur_reg == HT_ROUTING)
                begin
                    if (o == POS_W'(2))
                    begin
                        rtype_next = b;
                    end
                    else if ((o == POS_W'(3)) && (rtype_reg == 8'd0))
                    begin
                        recs[n] = '{kind: K_SEGS_LEFT, index: 7'd0, value: {56'd0, b},
                                    last: 1'b0};
                        n = n + 3'd1;
                    end
                    else if ((o >= POS_W'(8)) && (rtype_reg == 8'd0))
                    begin
                        if (lim <= {1'b0, hend_eff})
                        begin
                            acc_next = {acc_reg[55:0], b};
                            if (rel[3:0] == 4'd7)
                            begin
                                recs[n] = '{kind: K_ROUTE_HI, index: k[6:0], value: acc_next,
                                            last: 1'b0};
                                n = n + 3'd1;
                            end
                            else if (rel[3:0] == 4'd15)
                            begin
                                recs[n] = '{kind: K_ROUTE_LO, index: k[6:0], value: acc_next,
                                            last: 1'b0};
                                n = n + 3'd1;
                            end
                        end
                    end
                end
                else if (cur_reg == HT_FRAGMENT)
                begin
                    if ((o == POS_W'(2)) || (o == POS_W'(3)))
                    begin
                        frag_next = frag_new;
                    end
                    if (o == POS_W'(3))
                    begin
                        recs[n] = '{kind: K_FRAG_OFS, index: 7'd0,
                                    value: {51'd0, frag_new[15:3]}, last: 1'b0};
                        n = n + 3'd1;
                        recs[n] = '{kind: K_FRAG_MORE, index: 7'd0,
                                    value: {63'd0, frag_new[0]}, last: 1'b0};
                        n = n + 3'd1;
                    end
                    else if ((o >= POS_W'(4)) && (o <= POS_W'(7)))
                    begin
                        acc_next = {acc_reg[55:0], b};
                        if (o == POS_W'(7))
                        begin
                            recs[n] = '{kind: K_FRAG_ID, index: 7'd0,
                                        value: {32'd0, acc_next[31:0]}, last: 1'b0};
                            n = n + 3'd1;
                        end
                    end
                end

                if (({1'b0, pos_reg} + 18'd1) == {1'b0, hend_eff})
                begin
                    do_enter  = 1'b1;
                    ent_type  = nxt_eff;
                    ent_start = hend_eff;
                end
            end
        end

        // Step into the next header, or finish the chain on an upper-layer type.
        if (do_enter)
        begin
            cur_next    = ent_type;
            hstart_next = ent_start;
            if (is_ext(ent_type))
            begin
                phase_next = PH_CHAIN;
                hend_next  = ent_start + POS_W'(8);
                rtype_next = 8'd0;
                frag_next  = 16'd0;
                acc_next   = 64'd0;
            end
            else
            begin
                recs[n] = '{kind: K_PROTOCOL, index: 7'd0, value: {56'd0, ent_type},
                            last: 1'b0};
                n = n + 3'd1;
                recs[n] = '{kind: K_PAY_OFS, index: 7'd0, value: 64'(ent_start),
                            last: 1'b0};
                n = n + 3'd1;
                phase_next = PH_DONE;
            end
        end

        // End of packet, or advance the saturating byte position.
        if (byte_in.last_byte)
        begin
            if (phase_next == PH_CHAIN)
            begin
                recs[n] = '{kind: K_TRUNCATED, index: 7'd0, value: 64'd0, last: 1'b0};
                n = n + 3'd1;
            end
            phase_next = PH_FIXED;
            pos_next   = '0;
        end
        else if (pos_reg != '1)
        begin
            pos_next = pos_reg + POS_W'(1);
        end

        if (n != 3'd0)
        begin
            recs[n - 3'd1].last = 1'b1;
        end
    end

    // Pending list: loaded on an accepted byte, shifted out one record per cycle while the queue takes it.
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_REC; i++)
        begin
            pend_next[i] = pend_reg[i];
        end
        if (accept)
        begin
            cnt_next = n;
            for (int i = 0; i < MAX_REC; i++)
            begin
                pend_next[i] = recs[i];
            end
        end
        else if (push)
        begin
            cnt_next = cnt_reg - 3'd1;
            for (int i = 0; i < MAX_REC - 1; i++)
            begin
                pend_next[i] = pend_reg[i + 1];
            end
            pend_next[MAX_REC - 1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIXED;
            pos_reg    <= '0;
            cur_reg    <= '0;
            nxt_reg    <= '0;
            hstart_reg <= '0;
            hend_reg   <= '0;
            rtype_reg  <= '0;
            frag_reg   <= '0;
            hop_reg    <= '0;
            acc_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                cur_reg    <= cur_next;
                nxt_reg    <= nxt_next;
                hstart_reg <= hstart_next;
                hend_reg   <= hend_next;
                rtype_reg  <= rtype_next;
                frag_reg   <= frag_next;
                hop_reg    <= hop_next;
                acc_reg    <= acc_next;
            end
        end
    end

    // Address halves and pending records carry payload only.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 4; i++)
            begin
                halves_reg[i] <= halves_next[i];
            end
        end
        for (int i = 0; i < MAX_REC; i++)
        begin
            pend_reg[i] <= pend_next[i];
        end
    end

endmodule

// ===== rtl/ihcp_queue.sv =====
module ihcp_queue
    import ihcp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ihcp_rec_if.sink      rec_q,
    ihcp_rec_if.source    rec_out,
    output queue_stat_t   stat
);

    rec_t       mem [QUEUE_DEPTH];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] count_reg, count_next;
    logic       wr_en;
    logic       rd_en;

    assign rec_q.ready = (count_reg != 3'(QUEUE_DEPTH));
    assign wr_en       = rec_q.valid && rec_q.ready;
    assign rd_en       = rec_out.valid && rec_out.ready;

    assign rec_out.valid        = (count_reg != 3'd0);
    assign rec_out.record_kind  = mem[rd_reg].kind;
    assign rec_out.record_index = mem[rd_reg].index;
    assign rec_out.record_value = mem[rd_reg].value;
    assign rec_out.last_of_run  = mem[rd_reg].last;
    assign stat.count           = count_reg;

    // Pointer and fill-count update.
    always_comb
    begin
        wr_next    = wr_en ? wr_reg + 2'd1 : wr_reg;
        rd_next    = rd_en ? rd_reg + 2'd1 : rd_reg;
        count_next = count_reg + 3'(wr_en) - 3'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_reg] <= '{kind: rec_q.record_kind, index: rec_q.record_index,
                             value: rec_q.record_value, last: rec_q.last_of_run};
        end
    end

endmodule

// ===== rtl/ipv6_header_chain_parser.sv =====
// Channel   Dir  Payload                                              Item
// byte_in   in   data_byte[7:0], last_byte                            one packet byte
// rec_out   out  record_kind[3:0], record_index[6:0],                 one parse record
//                record_value[63:0], last_of_run
//
// A byte that causes no record or one record is taken every cycle while the queue has room.
// A byte that causes several records stalls the input until all but its last have left,
// since the front parser hands its records to the four-entry record queue one per cycle.
// The header byte at offset 39 causes up to seven records.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled output fills the record queue before it stops the byte input.
module ipv6_header_chain_parser
    import ihcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ihcp_byte_if.sink   byte_in,
    ihcp_rec_if.source  rec_out
);

`include "ipv6_header_chain_parser_assert.svh"

    ihcp_rec_if  rec_q ();
    front_stat_t front_stat;
    queue_stat_t queue_stat;

    // Front: parses bytes and produces records.
    ihcp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .rec_q   (rec_q),
        .stat    (front_stat)
    );

    // Back: record queue feeding the output.
    ihcp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .rec_q   (rec_q),
        .rec_out (rec_out),
        .stat    (queue_stat)
    );

    // A byte is only taken when the pending list is nearly drained.
    `IHCP_ASSERT_NOW(a_accept_drained, clk, rst_n, byte_in.valid && byte_in.ready,
        front_stat.pend_cnt <= 3'd1, "byte accepted with records still pending")
    // The queue never holds more than its depth.
    `IHCP_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1,
        queue_stat.count <= 3'(QUEUE_DEPTH), "record queue overfilled")
    // A full queue cannot take a record in the same cycle it stays unread.
    `IHCP_ASSERT_NEXT(a_full_holds, clk, rst_n,
        queue_stat.count == 3'(QUEUE_DEPTH) && !rec_out.ready,
        queue_stat.count == 3'(QUEUE_DEPTH), "full queue changed without a read")

endmodule

// ===== verif/ihcp_tb_ifs.sv =====
// Testbench-side copies are not needed; the RTL interfaces are used directly.
// This file holds the packet helper types shared by the testbench modules.
package ihcp_tb_pkg;
    import ihcp_pkg::*;

    // Parse phases of the predictor.
    typedef enum logic [1:0] {PH_FIXED, PH_CHAIN, PH_DONE} phase_e;

    // Upper-layer and terminating header types used to end a chain.
    localparam logic [7:0] HT_TCP    = 8'd6;
    localparam logic [7:0] HT_UDP    = 8'd17;
    localparam logic [7:0] HT_ICMPV6 = 8'd58;
    localparam logic [7:0] HT_NO_NXT = 8'd59;
    localparam logic [7:0] HT_IPV6   = 8'd41;
endpackage

// ===== verif/ihcp_checker.sv =====
module ihcp_checker
    import ihcp_pkg::*;
    import ihcp_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ihcp_byte_if        byte_in,
    ihcp_rec_if         rec_out,
    output int          fail_count,
    output int          pending_records
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [16:0] POS_MAX = 17'h1FFFF;

    // Parser state mirrored from the block's behavior.
    logic [16:0] pos;
    phase_e      phase;
    logic [7:0]  cur_type;
    logic [7:0]  nxt_type;
    logic [16:0] hdr_start;
    logic [16:0] hdr_end;
    logic [7:0]  route_type;
    logic [6:0]  route_count;
    logic [15:0] frag_flags;
    logic [7:0]  hop_limit;
    logic [63:0] addr_half [4];
    logic [63:0] acc;

    rec_t expected_records [$];
    rec_t byte_records [$];

    assign pending_records = expected_records.size();

    function automatic void add_record(input logic [3:0] kind, input logic [6:0] idx,
                                       input logic [63:0] val);
        rec_t r;
        if (byte_records.size() >= MAX_REC)
            return;
        r.kind = kind;
        r.index = idx;
        r.value = val;
        r.last = 1'b0;
        byte_records.push_back(r);
    endfunction

    function automatic logic is_extension(input logic [7:0] t);
        return t == HT_HOP_BY_HOP || t == HT_ROUTING || t == HT_FRAGMENT || t == HT_DEST_OPTS;
    endfunction

    function automatic void start_header(input logic [7:0] t, input logic [16:0] start);
        cur_type = t;
        hdr_start = start;
        if (is_extension(t)) begin
            phase = PH_CHAIN;
            hdr_end = start + 17'd8;
            route_type = '0;
            route_count = '0;
            frag_flags = '0;
            acc = '0;
        end
        else begin
            add_record(K_PROTOCOL, '0, 64'(t));
            add_record(K_PAY_OFS, '0, 64'(start));
            phase = PH_DONE;
        end
    endfunction

    function automatic void chain_step(input logic [16:0] p, input logic [7:0] b);
        logic [16:0] ofs;
        logic [16:0] rel;
        logic [16:0] k;
        ofs = p - hdr_start;
        if (ofs == 0)
            nxt_type = b;
        else if (ofs == 1 && cur_type != HT_FRAGMENT)
            hdr_end = hdr_start + (17'(b) + 17'd1) * 17'd8;

        if (cur_type == HT_ROUTING) begin
            if (ofs == 2)
                route_type = b;
            else if (ofs == 3 && route_type == 0)
                add_record(K_SEGS_LEFT, '0, 64'(b));
            else if (ofs >= 8 && route_type == 0) begin
                rel = ofs - 17'd8;
                k = (rel >> 4) + 17'd1;
                if (32'(hdr_start) + 32'd8 + 32'd16 * 32'(k) <= 32'(hdr_end)) begin
                    acc = {acc[55:0], b};
                    route_count = k[6:0];
                    if (rel[3:0] == 4'd7)
                        add_record(K_ROUTE_HI, k[6:0], acc);
                    else if (rel[3:0] == 4'd15)
                        add_record(K_ROUTE_LO, k[6:0], acc);
                end
            end
        end
        else if (cur_type == HT_FRAGMENT) begin
            if (ofs == 2 || ofs == 3)
                frag_flags = {frag_flags[7:0], b};
            if (ofs == 3) begin
                add_record(K_FRAG_OFS, '0, 64'((frag_flags & 16'hFFF8) >> 3));
                add_record(K_FRAG_MORE, '0, 64'(frag_flags & 16'h0001));
            end
            else if (ofs >= 4 && ofs <= 7) begin
                acc = {acc[55:0], b};
                if (ofs == 7)
                    add_record(K_FRAG_ID, '0, {32'd0, acc[31:0]});
            end
        end

        if (32'(p) + 1 == 32'(hdr_end))
            start_header(nxt_type, hdr_end);
    endfunction

    // Works out the records caused by one packet byte.
    function automatic void predict_byte(input logic [7:0] b, input logic lst);
        logic [16:0] p;
        p = pos;
        byte_records.delete();
        if (phase == PH_FIXED) begin
            if (p == 6)
                nxt_type = b;
            else if (p == 7)
                hop_limit = b;
            if (p >= 8 && p <= 39) begin
                acc = {acc[55:0], b};
                if (p[2:0] == 3'd7)
                    addr_half[(p - 17'd8) >> 3] = acc;
            end
            if (p == 39) begin
                add_record(K_DST_HI, '0, addr_half[2]);
                add_record(K_DST_LO, '0, addr_half[3]);
                add_record(K_SRC_HI, '0, addr_half[0]);
                add_record(K_SRC_LO, '0, addr_half[1]);
                add_record(K_HOP_LIMIT, '0, 64'(hop_limit));
                start_header(nxt_type, 17'd40);
            end
            else if (lst)
                add_record(K_TOO_SHORT, '0, 64'(p) + 64'd1);
        end
        else if (phase == PH_CHAIN) begin
            if (32'(p) >= MAX_PACKET_BYTES) begin
                add_record(K_TRUNCATED, '0, '0);
                phase = PH_DONE;
            end
            else
                chain_step(p, b);
        end

        if (lst) begin
            if (phase == PH_CHAIN)
                add_record(K_TRUNCATED, '0, '0);
            phase = PH_FIXED;
            pos = '0;
        end
        else if (p < POS_MAX)
            pos = p + 17'd1;

        if (byte_records.size() > 0)
            byte_records[byte_records.size() - 1].last = 1'b1;
        foreach (byte_records[i])
            expected_records.push_back(byte_records[i]);
    endfunction

    // Predicts on each accepted byte and compares each accepted record.
    always @(posedge clk or negedge rst_n)
    begin
        rec_t exp_rec;
        int   errs;
        errs = 0;
        if (!rst_n) begin
            pos <= '0;
            phase <= PH_FIXED;
            cur_type <= '0;
            nxt_type <= '0;
            hdr_start <= '0;
            hdr_end <= '0;
            route_type <= '0;
            route_count <= '0;
            frag_flags <= '0;
            hop_limit <= '0;
            acc <= '0;
            fail_count <= 0;
            expected_records.delete();
        end
        else begin
            if (rec_out.valid && rec_out.ready) begin
                if (expected_records.size() == 0) begin
                    $error("unexpected record kind %0d value %h", rec_out.record_kind,
                           rec_out.record_value);
                    errs++;
                end
                else begin
                    exp_rec = expected_records.pop_front();
                    if (rec_out.record_kind !== exp_rec.kind) begin
                        $error("record_kind: expected %0d, actual %0d", exp_rec.kind,
                               rec_out.record_kind);
                        errs++;
                    end
                    if (rec_out.record_index !== exp_rec.index) begin
                        $error("record_index: expected %0d, actual %0d", exp_rec.index,
                               rec_out.record_index);
                        errs++;
                    end
                    if (rec_out.record_value !== exp_rec.value) begin
                        $error("record_value: expected %h, actual %h", exp_rec.value,
                               rec_out.record_value);
                        errs++;
                    end
                    if (rec_out.last_of_run !== exp_rec.last) begin
                        $error("last_of_run: expected %0d, actual %0d", exp_rec.last,
                               rec_out.last_of_run);
                        errs++;
                    end
                end
                fail_count <= fail_count + errs;
            end
            // The byte is predicted after the record pop so a record from this
            // same byte is never matched in the cycle it is accepted.
            if (byte_in.valid && byte_in.ready)
                predict_byte(byte_in.data_byte, byte_in.last_byte);
        end
    end
endmodule

// ===== verif/testbench.sv =====
module testbench;
    import ihcp_pkg::*;
    import ihcp_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_records;
    int   bytes_sent;
    logic hold_off;
    logic no_idle;

    ihcp_byte_if byte_in ();
    ihcp_rec_if  rec_out ();

    ipv6_header_chain_parser u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in.sink),
        .rec_out (rec_out.source)
    );

    ihcp_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_in         (byte_in),
        .rec_out         (rec_out),
        .fail_count      (fail_count),
        .pending_records (pending_records)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on run time.
    initial
    begin
        #100us;
        $display("FAIL");
        $finish;
    end

    // Record receiver: random stalls, one long hold-off, one stall-free stretch.
    initial
    begin
        rec_out.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off)
                rec_out.ready <= 1'b0;
            else if (no_idle)
                rec_out.ready <= 1'b1;
            else
                rec_out.ready <= ($urandom_range(99) >= 20);
        end
    end

    logic [7:0] pkt [$];

    // Sends one packet with random idle gaps. Ready only changes at the rising
    // edge, so its value at the falling edge tells whether the next edge accepts.
    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++) begin
            if (!no_idle)
                while ($urandom_range(99) < 20) begin
                    byte_in.valid <= 1'b0;
                    @(negedge clk);
                end
            byte_in.valid <= 1'b1;
            byte_in.data_byte <= pkt[i];
            byte_in.last_byte <= (i == pkt.size() - 1);
            while (!byte_in.ready)
                @(negedge clk);
            @(posedge clk);
            bytes_sent++;
            @(negedge clk);
        end
        byte_in.valid <= 1'b0;
    endtask

    // Fixed header with random addresses.
    task automatic make_fixed(input logic [7:0] first_nh);
        pkt.delete();
        for (int i = 0; i < 40; i++)
            pkt.push_back(8'($urandom));
        pkt[6] = first_nh;
    endtask

    // Appends an extension header of the given type; len in 8-byte units.
    task automatic add_ext(input logic [7:0] t, input logic [7:0] nh, input logic [7:0] len,
                           input logic [7:0] rtype);
        int n;
        n = (t == HT_FRAGMENT) ? 8 : (int'(len) + 1) * 8;
        for (int i = 0; i < n; i++)
            pkt.push_back(8'($urandom));
        pkt[pkt.size() - n] = nh;
        if (t != HT_FRAGMENT)
            pkt[pkt.size() - n + 1] = len;
        if (t == HT_ROUTING)
            pkt[pkt.size() - n + 2] = rtype;
    endtask

    function automatic logic [7:0] rand_ext();
        case ($urandom_range(3))
            0: return HT_HOP_BY_HOP;
            1: return HT_ROUTING;
            2: return HT_FRAGMENT;
            default: return HT_DEST_OPTS;
        endcase
    endfunction

    function automatic logic [7:0] rand_final();
        case ($urandom_range(5))
            0: return HT_TCP;
            1: return HT_UDP;
            2: return HT_ICMPV6;
            3: return HT_NO_NXT;
            4: return HT_IPV6;
            default: return 8'($urandom);
        endcase
    endfunction

    // Builds a well-formed chain of random depth, sometimes cut off or padded.
    task automatic make_chain();
        int depth;
        logic [7:0] t;
        logic [7:0] nt;
        depth = $urandom_range(3);
        t = (depth == 0) ? rand_final() : rand_ext();
        make_fixed(t);
        for (int d = 0; d < depth; d++) begin
            nt = (d == depth - 1) ? rand_final() : rand_ext();
            add_ext(t, nt, 8'($urandom_range(4)), ($urandom_range(3) == 0) ? 8'd2 : 8'd0);
            t = nt;
        end
        if ($urandom_range(3) == 0)
            pkt = pkt[0:$urandom_range(pkt.size() - 1)];
        else
            repeat ($urandom_range(6))
                pkt.push_back(8'($urandom));
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n = 1'b0;
        hold_off = 1'b0;
        no_idle = 1'b0;
        bytes_sent = 0;
        byte_in.valid = 1'b0;
        byte_in.data_byte = '0;
        byte_in.last_byte = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Short packets: a single byte, and 39 bytes of extremes.
        pkt = '{8'hFF};
        send_packet();
        pkt.delete();
        for (int i = 0; i < 39; i++)
            pkt.push_back((i % 2) ? 8'hFF : 8'h00);
        send_packet();

        // Stall-free stretch: fixed header straight to TCP, then each extension
        // header in turn, with a routing header of odd length.
        no_idle = 1'b1;
        make_fixed(HT_TCP);
        send_packet();
        make_fixed(HT_HOP_BY_HOP);
        add_ext(HT_HOP_BY_HOP, HT_ROUTING, 8'd0, 8'd0);
        add_ext(HT_ROUTING, HT_FRAGMENT, 8'd3, 8'd0);
        add_ext(HT_FRAGMENT, HT_DEST_OPTS, 8'd0, 8'd0);
        pkt[pkt.size() - 6] = 8'hFF;
        pkt[pkt.size() - 5] = 8'hFF;
        add_ext(HT_DEST_OPTS, HT_UDP, 8'd0, 8'd0);
        send_packet();
        no_idle = 1'b0;

        // Non-zero routing type, and a cut-off chain.
        make_fixed(HT_ROUTING);
        add_ext(HT_ROUTING, HT_NO_NXT, 8'd0, 8'd3);
        send_packet();
        make_fixed(HT_DEST_OPTS);
        pkt.push_back(HT_TCP);
        send_packet();

        // Long receiver hold-off while bytes keep coming.
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                repeat (2)
                begin
                    make_fixed(HT_UDP);
                    send_packet();
                end
            end
        join

        // Random packets.
        while (bytes_sent < 350) begin
            if ($urandom_range(9) == 0) begin
                pkt.delete();
                repeat ($urandom_range(1, 45))
                    pkt.push_back(8'($urandom));
            end
            else
                make_chain();
            send_packet();
        end

        while (pending_records != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
